@@ rtl/assert_macros.svh @@
// Assertion macros shared by the LED pattern sequencer RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/lps_pkg.sv @@
// Package for the LED pattern sequencer: command codes, mode type,
// item struct and the CIE1931 brightness curve. No dependencies.
`default_nettype none

package lps_pkg;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ON      = 3'd1;
  localparam logic [2:0] CMD_BLINK   = 3'd2;
  localparam logic [2:0] CMD_OFF     = 3'd3;
  localparam logic [2:0] CMD_FLICKER = 3'd4;
  localparam logic [2:0] CMD_BREATH  = 3'd5;

  localparam logic [2:0] REG_STANDBY    = 3'd0;
  localparam logic [2:0] REG_BLINK_ON   = 3'd1;
  localparam logic [2:0] REG_BLINK_OFF  = 3'd2;
  localparam logic [2:0] REG_BLINK_WAIT = 3'd3;
  localparam logic [2:0] REG_FLICKER    = 3'd4;
  localparam logic [2:0] REG_BREATH     = 3'd5;

  localparam int CURVE_LEN = 256;

  // floor(x / 10) = (x * DIV10_MUL) >> DIV10_SHIFT for any 16-bit x
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_ON      = 3'd1,
    MODE_BLINK   = 3'd2,
    MODE_FLICKER = 3'd3,
    MODE_BREATH  = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] blink_times;
  } item_t;

  localparam logic [15:0] CIE_CURVE [CURVE_LEN] = '{
    16'd0, 16'd28, 16'd57, 16'd85, 16'd114, 16'd142, 16'd171, 16'd199, 16'd228, 16'd256,
    16'd285, 16'd313, 16'd342, 16'd370, 16'd399, 16'd427, 16'd456, 16'd484, 16'd513,
    16'd541, 16'd570, 16'd598, 16'd627, 16'd658, 16'd689, 16'd721, 16'd755, 16'd789,
    16'd825, 16'd861, 16'd899, 16'd937, 16'd977, 16'd1018, 16'd1060, 16'd1103, 16'd1147,
    16'd1192, 16'd1239, 16'd1287, 16'd1336, 16'd1386, 16'd1437, 16'd1490, 16'd1544,
    16'd1599, 16'd1656, 16'd1714, 16'd1773, 16'd1834, 16'd1896, 16'd1959, 16'd2024,
    16'd2090, 16'd2157, 16'd2226, 16'd2297, 16'd2369, 16'd2442, 16'd2517, 16'd2593,
    16'd2671, 16'd2751, 16'd2832, 16'd2914, 16'd2999, 16'd3085, 16'd3172, 16'd3261,
    16'd3352, 16'd3444, 16'd3538, 16'd3634, 16'd3732, 16'd3831, 16'd3932, 16'd4035,
    16'd4139, 16'd4245, 16'd4354, 16'd4464, 16'd4575, 16'd4689, 16'd4804, 16'd4922,
    16'd5041, 16'd5162, 16'd5285, 16'd5410, 16'd5537, 16'd5666, 16'd5797, 16'd5930,
    16'd6065, 16'd6202, 16'd6341, 16'd6482, 16'd6626, 16'd6771, 16'd6918, 16'd7068,
    16'd7220, 16'd7373, 16'd7529, 16'd7687, 16'd7848, 16'd8010, 16'd8175, 16'd8342,
    16'd8512, 16'd8683, 16'd8857, 16'd9033, 16'd9212, 16'd9393, 16'd9576, 16'd9762,
    16'd9949, 16'd10140, 16'd10333, 16'd10528, 16'd10725, 16'd10926, 16'd11128,
    16'd11333, 16'd11541, 16'd11751, 16'd11963, 16'd12179, 16'd12396, 16'd12617,
    16'd12840, 16'd13065, 16'd13293, 16'd13524, 16'd13757, 16'd13993, 16'd14232,
    16'd14474, 16'd14718, 16'd14965, 16'd15215, 16'd15467, 16'd15722, 16'd15980,
    16'd16241, 16'd16505, 16'd16771, 16'd17041, 16'd17313, 16'd17588, 16'd17866,
    16'd18147, 16'd18431, 16'd18717, 16'd19007, 16'd19300, 16'd19596, 16'd19894,
    16'd20196, 16'd20501, 16'd20809, 16'd21119, 16'd21433, 16'd21750, 16'd22071,
    16'd22394, 16'd22720, 16'd23050, 16'd23383, 16'd23719, 16'd24058, 16'd24400,
    16'd24746, 16'd25095, 16'd25447, 16'd25802, 16'd26161, 16'd26523, 16'd26888,
    16'd27257, 16'd27629, 16'd28004, 16'd28383, 16'd28765, 16'd29151, 16'd29540,
    16'd29932, 16'd30328, 16'd30728, 16'd31131, 16'd31537, 16'd31947, 16'd32360,
    16'd32777, 16'd33198, 16'd33622, 16'd34050, 16'd34481, 16'd34916, 16'd35355,
    16'd35797, 16'd36243, 16'd36693, 16'd37146, 16'd37603, 16'd38064, 16'd38529,
    16'd38997, 16'd39469, 16'd39945, 16'd40425, 16'd40908, 16'd41396, 16'd41887,
    16'd42382, 16'd42881, 16'd43384, 16'd43891, 16'd44401, 16'd44916, 16'd45435,
    16'd45957, 16'd46484, 16'd47015, 16'd47549, 16'd48088, 16'd48631, 16'd49178,
    16'd49728, 16'd50283, 16'd50843, 16'd51406, 16'd51973, 16'd52545, 16'd53120,
    16'd53700, 16'd54284, 16'd54873, 16'd55465, 16'd56062, 16'd56663, 16'd57269,
    16'd57878, 16'd58492, 16'd59111, 16'd59733, 16'd60360, 16'd60992, 16'd61627,
    16'd62268, 16'd62912, 16'd63561, 16'd64215, 16'd64873, 16'd65535
  };

endpackage

`default_nettype wire

@@ rtl/lps_in_stage.sv @@
// Input register of the LED pattern sequencer: holds one accepted transfer
// until the step logic consumes it. Depends on lps_pkg.
`default_nettype none

module lps_in_stage
  import lps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  input  wire logic  take,
  output logic       held_valid,
  output item_t      held_item
);

  logic  vld;
  item_t item;

  assign in_ready   = !vld || take;
  assign held_valid = vld;
  assign held_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lps_curve.sv @@
// Breathing duty lookup: CIE1931 table entry, divide by ten through a
// reciprocal multiply, subtract from the dark level. Depends on lps_pkg.
`default_nettype none

module lps_curve
  import lps_pkg::*;
#(
  parameter int DUTY_MAX = 6553,
  parameter int DW       = 13
) (
  input  wire logic [7:0]    curve_pos,
  output logic      [DW-1:0] duty
);

  localparam logic [16:0] DMAX = 17'(DUTY_MAX);

  logic [15:0] entry;
  logic [31:0] prod;
  logic [12:0] sub;
  logic [16:0] diff;

  always_comb begin
    entry = CIE_CURVE[curve_pos];
    prod  = 32'(entry) * 32'(DIV10_MUL);
    sub   = prod[DIV10_SHIFT +: 13];
    diff  = (DMAX >= 17'(sub)) ? (DMAX - 17'(sub)) : 17'd0;
    duty  = diff[DW-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/led_pattern_sequencer_core.sv @@
// Each input transfer passes the input register, then the output register; throughput is one item per
// cycle while the receiver keeps m_tready high, sustained through both registers.
// The step logic (timestamp compares, mode state, curve lookup) sits between them.
// Reset (rst, synchronous) clears the stream stages, restores the register defaults,
// starts in flicker mode with the LED dark and the breathing index rising from zero.
// Depends on lps_pkg, lps_in_stage, lps_curve and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module led_pattern_sequencer_core
  import lps_pkg::*;
#(
  parameter int DUTY_MAX    = 6553,
  parameter int CURVE_STEPS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] blink_times
  input  wire logic [2:0]  s_tuser,   // [2:0] cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [15:0] m_tdata,   // [12:0] duty, [15:13] led_mode
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DW  = $clog2(DUTY_MAX + 1);
  localparam int IW  = $clog2(CURVE_STEPS);
  localparam int TOP = CURVE_STEPS - 1;
  localparam int RW  = $clog2(TOP);
  localparam int QS  = 255 / TOP;
  localparam int RS  = 255 % TOP;
  localparam logic [IW-1:0] IDX_TOP = IW'(TOP);
  localparam logic [RW:0]   REM_TOP = (RW + 1)'(TOP);
  localparam logic [RW:0]   REM_STEP = (RW + 1)'(RS);
  localparam logic [7:0]    POS_STEP = 8'(QS);
  localparam logic [DW-1:0] DARK = DW'(DUTY_MAX);

  // configuration
  logic [31:0] standby_ms;
  logic [15:0] blink_on_ms, blink_off_ms, blink_wait_ms, flicker_ms;
  logic [7:0]  breath_step_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      standby_ms     <= 32'd900000;
      blink_on_ms    <= 16'd200;
      blink_off_ms   <= 16'd200;
      blink_wait_ms  <= 16'd2000;
      flicker_ms     <= 16'd100;
      breath_step_ms <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STANDBY:    standby_ms     <= cfg_data;
        REG_BLINK_ON:   blink_on_ms    <= cfg_data[15:0];
        REG_BLINK_OFF:  blink_off_ms   <= cfg_data[15:0];
        REG_BLINK_WAIT: blink_wait_ms  <= cfg_data[15:0];
        REG_FLICKER:    flicker_ms     <= cfg_data[15:0];
        REG_BREATH:     breath_step_ms <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input stage
  logic  adv, in_vld, out_vld;
  item_t in_item, item;

  assign in_item = '{cmd: s_tuser, blink_times: s_tdata};
  assign adv     = in_vld && (!out_vld || m_tready);

  lps_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .take      (adv),
    .held_valid(in_vld),
    .held_item (item)
  );

  // state
  logic [31:0]   now_ms, now_p1, activity_stamp, blink_stamp, flicker_stamp, breath_stamp;
  logic [31:0]   now_ms_next, now_p1_next, activity_stamp_next, blink_stamp_next;
  logic [31:0]   flicker_stamp_next, breath_stamp_next;
  mode_t         cur_mode, cur_mode_next;
  logic [7:0]    blink_target, blink_done, blink_target_next, blink_done_next;
  logic          blink_lit, flicker_lit, breath_rising;
  logic          blink_lit_next, flicker_lit_next, breath_rising_next;
  logic [IW-1:0] breath_index, breath_index_next;
  logic [7:0]    curve_pos, curve_pos_next;
  logic [RW-1:0] curve_rem, curve_rem_next;
  logic [DW-1:0] duty_reg, duty_reg_next, breath_duty;

  // breathing step: index moves by one, curve position tracks index*255/TOP
  logic [IW-1:0] idx_step;
  logic [7:0]    pos_step;
  logic [RW:0]   rem_sum, rem_step;
  logic          step_up, step_dn;

  always_comb begin
    step_up  = breath_rising && (breath_index < IDX_TOP);
    step_dn  = !breath_rising && (breath_index != '0);
    idx_step = breath_index;
    pos_step = curve_pos;
    rem_step = {1'b0, curve_rem};
    rem_sum  = {1'b0, curve_rem} + REM_STEP;
    if (step_up) begin
      idx_step = breath_index + 1'b1;
      if (rem_sum >= REM_TOP) begin
        rem_step = rem_sum - REM_TOP;
        pos_step = curve_pos + POS_STEP + 8'd1;
      end else begin
        rem_step = rem_sum;
        pos_step = curve_pos + POS_STEP;
      end
    end else if (step_dn) begin
      idx_step = breath_index - 1'b1;
      if ({1'b0, curve_rem} < REM_STEP) begin
        rem_step = {1'b0, curve_rem} + REM_TOP - REM_STEP;
        pos_step = curve_pos - POS_STEP - 8'd1;
      end else begin
        rem_step = {1'b0, curve_rem} - REM_STEP;
        pos_step = curve_pos - POS_STEP;
      end
    end
  end

  lps_curve #(
    .DUTY_MAX(DUTY_MAX),
    .DW      (DW)
  ) u_curve (
    .curve_pos(pos_step),
    .duty     (breath_duty)
  );

  logic act_pass, on_pass, off_pass, wait_pass, flk_pass, br_pass;

  always_comb begin
    act_pass  = (now_p1 - activity_stamp) >= standby_ms;
    on_pass   = (now_p1 - blink_stamp) >= {16'd0, blink_on_ms};
    off_pass  = (now_p1 - blink_stamp) >= {16'd0, blink_off_ms};
    wait_pass = (now_p1 - blink_stamp) >= {16'd0, blink_wait_ms};
    flk_pass  = (now_p1 - flicker_stamp) >= {16'd0, flicker_ms};
    br_pass   = (now_p1 - breath_stamp) >= {24'd0, breath_step_ms};
  end

  always_comb begin
    now_ms_next         = now_ms;
    now_p1_next         = now_p1;
    activity_stamp_next = activity_stamp;
    blink_stamp_next    = blink_stamp;
    flicker_stamp_next  = flicker_stamp;
    breath_stamp_next   = breath_stamp;
    cur_mode_next       = cur_mode;
    blink_target_next   = blink_target;
    blink_done_next     = blink_done;
    blink_lit_next      = blink_lit;
    flicker_lit_next    = flicker_lit;
    breath_rising_next  = breath_rising;
    breath_index_next   = breath_index;
    curve_pos_next      = curve_pos;
    curve_rem_next      = curve_rem;
    duty_reg_next       = duty_reg;
    if (adv) begin
      case (item.cmd)
        CMD_TICK: begin
          now_ms_next = now_p1;
          now_p1_next = now_p1 + 32'd1;
          case (cur_mode)
            MODE_OFF: duty_reg_next = DARK;
            MODE_ON: begin
              if (act_pass) begin
                cur_mode_next = MODE_OFF;
                duty_reg_next = DARK;
              end else begin
                duty_reg_next = '0;
              end
            end
            MODE_BLINK: begin
              if (blink_done >= blink_target) begin
                if (wait_pass) begin
                  blink_stamp_next = now_p1;
                  blink_done_next  = 8'd0;
                end
              end else if (blink_lit) begin
                if (on_pass) begin
                  blink_stamp_next = now_p1;
                  duty_reg_next    = DARK;
                  blink_lit_next   = 1'b0;
                  blink_done_next  = blink_done + 8'd1;
                end
              end else if (off_pass) begin
                blink_stamp_next = now_p1;
                duty_reg_next    = '0;
                blink_lit_next   = 1'b1;
              end
            end
            MODE_FLICKER: begin
              if (flk_pass) begin
                duty_reg_next      = flicker_lit ? '0 : DARK;
                flicker_stamp_next = now_p1;
                flicker_lit_next   = !flicker_lit;
              end
            end
            MODE_BREATH: begin
              if (br_pass) begin
                breath_stamp_next = now_p1;
                breath_index_next = idx_step;
                curve_pos_next    = pos_step;
                curve_rem_next    = rem_step[RW-1:0];
                if (idx_step == '0) begin
                  breath_rising_next = 1'b1;
                end else if (idx_step == IDX_TOP) begin
                  breath_rising_next = 1'b0;
                end
                duty_reg_next = breath_duty;
              end
            end
            default: ;
          endcase
        end
        CMD_ON: begin
          activity_stamp_next = now_ms;
          cur_mode_next       = MODE_ON;
          duty_reg_next       = '0;
        end
        CMD_BLINK: begin
          if (!(cur_mode == MODE_BLINK && blink_target == item.blink_times)) begin
            cur_mode_next     = MODE_BLINK;
            blink_target_next = item.blink_times;
            blink_done_next   = item.blink_times;
            blink_lit_next    = 1'b0;
            blink_stamp_next  = now_ms;
            duty_reg_next     = DARK;
          end
        end
        CMD_OFF:     cur_mode_next = MODE_OFF;
        CMD_FLICKER: cur_mode_next = MODE_FLICKER;
        CMD_BREATH:  cur_mode_next = MODE_BREATH;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ms         <= '0;
      now_p1         <= 32'd1;
      activity_stamp <= '0;
      blink_stamp    <= '0;
      flicker_stamp  <= '0;
      breath_stamp   <= '0;
      cur_mode       <= MODE_FLICKER;
      blink_target   <= '0;
      blink_done     <= '0;
      blink_lit      <= 1'b0;
      flicker_lit    <= 1'b0;
      breath_rising  <= 1'b1;
      breath_index   <= '0;
      curve_pos      <= '0;
      curve_rem      <= '0;
      duty_reg       <= DARK;
    end else begin
      now_ms         <= now_ms_next;
      now_p1         <= now_p1_next;
      activity_stamp <= activity_stamp_next;
      blink_stamp    <= blink_stamp_next;
      flicker_stamp  <= flicker_stamp_next;
      breath_stamp   <= breath_stamp_next;
      cur_mode       <= cur_mode_next;
      blink_target   <= blink_target_next;
      blink_done     <= blink_done_next;
      blink_lit      <= blink_lit_next;
      flicker_lit    <= flicker_lit_next;
      breath_rising  <= breath_rising_next;
      breath_index   <= breath_index_next;
      curve_pos      <= curve_pos_next;
      curve_rem      <= curve_rem_next;
      duty_reg       <= duty_reg_next;
    end
  end

  // output register
  logic [15:0] duty_wide;
  logic [12:0] out_duty;
  logic [2:0]  out_mode;

  assign duty_wide = 16'(duty_reg_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (adv) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_duty <= duty_wide[12:0];
      out_mode <= cur_mode_next;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {out_mode, out_duty};

  `ASSERT_IMPLIES(a_on_lit, clk, rst, cur_mode == MODE_ON, duty_reg == '0, "on mode not lit")
  `ASSERT_ALWAYS(a_blink_count, clk, rst, blink_done <= blink_target, "blink count overrun")
  `ASSERT_ALWAYS(a_breath_range, clk, rst, breath_index <= IDX_TOP && {1'b0, curve_rem} < REM_TOP,
    "breathing index or remainder out of range")
  `ASSERT_NEXT(a_adv_out, clk, rst, adv, m_tvalid, "step result not presented")

endmodule

`default_nettype wire

@@ sim/tb_led_pattern_sequencer_core.sv @@
// Testbench for led_pattern_sequencer_core: directed and random tick/command streams,
// duty and mode checked against a cycle-free predictor kept in a small scoreboard class.
// Depends on lps_pkg and the RTL of the sequencer core.
`timescale 1ns / 100ps

module tb_led_pattern_sequencer_core
  import lps_pkg::*;
();

  localparam int LED_DARK    = 6553;
  localparam int CURVE_STEPS = 256;
  localparam int CURVE_TOP   = CURVE_STEPS - 1;
  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 10;
  localparam int SWEEP_TICKS = 270;

  // unused command codes, ignored by the block
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam logic [2:0] REG_ORDER [6] = '{REG_STANDBY, REG_BLINK_ON, REG_BLINK_OFF,
                                           REG_BLINK_WAIT, REG_FLICKER, REG_BREATH};

  typedef enum {CFG_SMALL, CFG_ONES, CFG_MAX, CFG_ZERO, CFG_WIDE, CFG_SWEEP} cfg_kind_t;

  class led_pattern_board;
    bit [31:0] standby;
    bit [15:0] pulse_on, blink_off, blink_wait, flicker_half;
    bit [7:0]  breath_step;
    bit [31:0] now_ms, act_stamp, blink_stamp, flick_stamp, breath_stamp;
    mode_t     mode;
    bit [7:0]  blink_target, blink_done, breath_idx;
    bit        blink_lit, flick_lit, breath_up;
    bit [15:0] duty;
    bit [15:0] duty_q[$];
    int        errors;

    function new();
      standby      = 32'd900000;
      pulse_on     = 16'd200;
      blink_off    = 16'd200;
      blink_wait   = 16'd2000;
      flicker_half = 16'd100;
      breath_step  = 8'd5;
      mode         = MODE_FLICKER;
      breath_up    = 1'b1;
      duty         = 16'(LED_DARK);
      errors       = 0;
    endfunction

    function void set_reg(logic [2:0] idx, bit [31:0] val);
      case (idx)
        REG_STANDBY:    standby      = val;
        REG_BLINK_ON:   pulse_on     = val[15:0];
        REG_BLINK_OFF:  blink_off    = val[15:0];
        REG_BLINK_WAIT: blink_wait   = val[15:0];
        REG_FLICKER:    flicker_half = val[15:0];
        REG_BREATH:     breath_step  = val[7:0];
        default: ;
      endcase
    endfunction

    function bit elapsed(bit [31:0] stamp, bit [31:0] len);
      bit [31:0] diff;
      diff = now_ms - stamp;
      return diff >= len;
    endfunction

    function bit [15:0] curve_duty(bit [7:0] idx);
      int t;
      int sub;
      t   = (int'(idx) * 255) / CURVE_TOP;
      sub = int'(CIE_CURVE[t & 255]) / 10;
      return (sub <= LED_DARK) ? 16'(LED_DARK - sub) : 16'd0;
    endfunction

    function void run_tick();
      case (mode)
        MODE_OFF: duty = 16'(LED_DARK);
        MODE_ON: begin
          if (elapsed(act_stamp, standby)) begin
            mode = MODE_OFF;
            duty = 16'(LED_DARK);
          end else begin
            duty = 16'd0;
          end
        end
        MODE_BLINK: begin
          if (blink_done >= blink_target) begin
            if (elapsed(blink_stamp, blink_wait)) begin
              blink_stamp = now_ms;
              blink_done  = 8'd0;
            end
          end else if (blink_lit) begin
            if (elapsed(blink_stamp, pulse_on)) begin
              blink_stamp = now_ms;
              duty        = 16'(LED_DARK);
              blink_lit   = 1'b0;
              blink_done  = blink_done + 8'd1;
            end
          end else if (elapsed(blink_stamp, blink_off)) begin
            blink_stamp = now_ms;
            duty        = 16'd0;
            blink_lit   = 1'b1;
          end
        end
        MODE_FLICKER: begin
          if (elapsed(flick_stamp, flicker_half)) begin
            duty        = flick_lit ? 16'd0 : 16'(LED_DARK);
            flick_stamp = now_ms;
            flick_lit   = !flick_lit;
          end
        end
        MODE_BREATH: begin
          if (elapsed(breath_stamp, breath_step)) begin
            breath_stamp = now_ms;
            if (breath_up) begin
              if (breath_idx < CURVE_TOP) breath_idx = breath_idx + 8'd1;
            end else if (breath_idx > 0) begin
              breath_idx = breath_idx - 8'd1;
            end
            if (breath_idx == 0) breath_up = 1'b1;
            else if (breath_idx == CURVE_TOP) breath_up = 1'b0;
            duty = curve_duty(breath_idx);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] cmd, logic [7:0] times);
      case (cmd)
        CMD_TICK: begin
          now_ms = now_ms + 32'd1;
          run_tick();
        end
        CMD_ON: begin
          act_stamp = now_ms;
          mode      = MODE_ON;
          duty      = 16'd0;
        end
        CMD_BLINK: begin
          if (!(mode == MODE_BLINK && blink_target == times)) begin
            mode         = MODE_BLINK;
            blink_target = times;
            blink_done   = times;
            blink_lit    = 1'b0;
            blink_stamp  = now_ms;
            duty         = 16'(LED_DARK);
          end
        end
        CMD_OFF:     mode = MODE_OFF;
        CMD_FLICKER: mode = MODE_FLICKER;
        CMD_BREATH:  mode = MODE_BREATH;
        default: ;
      endcase
      duty_q.push_back({3'(mode), duty[12:0]});
    endfunction

    function void report(string what, bit [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%s: expected duty %0d mode %0d, got duty %0d mode %0d",
                 what, want[12:0], want[15:13], got[12:0], got[15:13]);
    endfunction

    function void check_output(logic [15:0] got);
      bit [15:0] want;
      if (duty_q.size() == 0) begin
        report("unexpected transfer", 16'd0, got);
      end else begin
        want = duty_q.pop_front();
        if (got[12:0] !== want[12:0] || got[15:13] !== want[15:13])
          report("mismatch", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic [2:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  bit stall_long = 1'b0;
  bit no_idle    = 1'b0;
  int cycle_count = 0;

  led_pattern_board board;

  led_pattern_sequencer_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_pattern_sequencer_core test failed");
      $finish;
    end
  end

  // result checked before the new input is noted; latency keeps them apart
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) board.check_output(m_tdata);
      if (s_tvalid && s_tready) board.note_item(s_tuser, s_tdata);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random backpressure, one long hold-off on request
  initial begin
    int gap;
    m_tready = 1'b0;
    forever begin
      if (stall_long) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_long = 1'b0;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        gap = pick_gap();
        if (gap == 0) gap = 1;
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic [2:0] cmd, input logic [7:0] times);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= times;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // the first wait lets the last transfer reach the queue before it is polled
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.duty_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_kind_t kind);
    bit [31:0] vals [6];
    case (kind)
      CFG_ONES: vals = '{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1};
      CFG_MAX:  vals = '{32'hFFFF_FFFF, 32'd65535, 32'd65535, 32'd65535, 32'd65535, 32'd255};
      CFG_ZERO: vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
      CFG_WIDE: vals = '{$urandom, 32'($urandom_range(0, 65535)),
                         32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
                         32'($urandom_range(0, 65535)), 32'($urandom_range(0, 255))};
      default: begin
        vals[0] = 32'($urandom_range(1, 40));
        vals[1] = 32'($urandom_range(1, 4));
        vals[2] = 32'($urandom_range(1, 4));
        vals[3] = 32'($urandom_range(1, 8));
        vals[4] = 32'($urandom_range(1, 5));
        vals[5] = (kind == CFG_SWEEP) ? 32'd1 : 32'($urandom_range(1, 3));
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_data  <= vals[i];
      board.set_reg(REG_ORDER[i], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // a command followed by a burst of ticks; noise codes do not count
  task automatic run_phase(input int n_items);
    int sent;
    int r;
    logic [2:0] cmd;
    logic [7:0] times;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      times = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, 3));
      if (r < 3)       cmd = CMD_RSVD6;
      else if (r < 6)  cmd = CMD_RSVD7;
      else if (r < 26) cmd = CMD_ON;
      else if (r < 46) cmd = CMD_BLINK;
      else if (r < 58) cmd = CMD_OFF;
      else if (r < 76) cmd = CMD_FLICKER;
      else if (r < 96) cmd = CMD_BREATH;
      else             cmd = CMD_TICK;
      send_item(cmd, times);
      if (cmd != CMD_RSVD6 && cmd != CMD_RSVD7) sent++;
      r = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 20);
      send_ticks(r);
      sent += r;
    end
  endtask

  initial begin
    cfg_kind_t kind;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    s_tuser   = CMD_TICK;
    cfg_we    = 1'b0;
    cfg_index = REG_STANDBY;
    cfg_data  = 32'd0;
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset register values
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_RSVD6, 8'hFF);
    send_item(CMD_RSVD7, 8'h00);
    send_item(CMD_ON, 8'hA5);
    send_item(CMD_TICK, 8'h5A);
    send_item(CMD_OFF, 8'h00);
    send_item(CMD_TICK, 8'hFF);
    send_item(CMD_BLINK, 8'h00);    // zero count: dark for good
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BLINK, 8'h00);    // same count while blinking: ignored
    send_item(CMD_BLINK, 8'hFF);
    send_item(CMD_FLICKER, 8'h00);
    send_item(CMD_TICK, 8'h00);
    send_item(CMD_BREATH, 8'h00);
    send_item(CMD_TICK, 8'h00);
    drain();

    // zero timing registers: every tick counts as elapsed
    load_settings(CFG_ZERO);
    send_item(CMD_ON, 8'h00);
    send_ticks(1);
    send_item(CMD_FLICKER, 8'h00);
    send_ticks(2);
    send_item(CMD_BREATH, 8'h00);
    send_ticks(2);
    send_item(CMD_BLINK, 8'h01);
    send_ticks(3);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       kind = CFG_ONES;
        3:       kind = CFG_MAX;
        6:       kind = CFG_ZERO;
        7:       kind = CFG_WIDE;
        default: kind = CFG_SMALL;
      endcase
      load_settings(kind);
      if (p == 4) stall_long = 1'b1;
      no_idle = (p == 5);
      run_phase(PHASE_ITEMS);
      no_idle = 1'b0;
      drain();
    end

    // breathing ramp long enough to pass at least one turning point
    load_settings(CFG_SWEEP);
    send_item(CMD_BREATH, 8'h00);
    send_ticks(SWEEP_TICKS);
    drain();

    repeat (6) @(posedge clk);
    board.errors += board.duty_q.size();
    if (board.errors == 0) begin
      $display("led_pattern_sequencer_core test passed");
    end else begin
      $display("led_pattern_sequencer_core test failed");
    end
    $finish;
  end

endmodule
